>>> sv/met_pkg.sv
// Shared constants, types and control structures for the escape-time counter.
package met_pkg;

    // Fraction bits of the fixed-point format of c and z.
    localparam int FRAC_BITS = 28;
    // Width of the input coordinates and of the iteration count.
    localparam int C_W       = 32;
    localparam int CNT_W     = 12;
    // z stays below 2^(C_W) in magnitude, so two extra bits hold it with sign.
    localparam int Z_W       = C_W + 2;
    // Magnitude width of a z part that has passed the large-component test.
    localparam int MAG_W     = FRAC_BITS + 1;
    // Exact square width; 4.0 at full precision is 2^SQ_W.
    localparam int SQ_W      = 2 * MAG_W;
    // Signed width of the cross product and of the difference of squares.
    localparam int XY_W      = 2 * (MAG_W + 1);
    localparam int DIFF_W    = SQ_W + 1;

    localparam logic [CNT_W-1:0] MAX_ITER_RESET = CNT_W'(511);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_FINISH
    } state_t;

    // Controls from the sequencer to the iteration unit.
    typedef struct packed {
        logic load;
        logic mul_en;
        logic update;
    } ctrl_t;

    // Status from the iteration unit to the sequencer.
    typedef struct packed {
        logic big;
        logic escape;
    } status_t;

endpackage

>>> sv/met_iter_unit.sv
// Iteration datapath: holds z and c, forms the products and the next z.
module met_iter_unit (
    input  logic                         clk,
    input  logic signed [met_pkg::C_W-1:0] c_real,
    input  logic signed [met_pkg::C_W-1:0] c_imag,
    input  met_pkg::ctrl_t               ctrl,
    output met_pkg::status_t             status
);
    import met_pkg::*;

    logic signed [C_W-1:0]    c_real_reg;
    logic signed [C_W-1:0]    c_imag_reg;
    logic signed [Z_W-1:0]    zx_reg;
    logic signed [Z_W-1:0]    zy_reg;
    logic signed [Z_W-1:0]    zx_next;
    logic signed [Z_W-1:0]    zy_next;
    logic [SQ_W-1:0]          x2_reg;
    logic [SQ_W-1:0]          y2_reg;
    logic signed [XY_W-1:0]   xy_reg;
    logic [SQ_W-1:0]          x2_next;
    logic [SQ_W-1:0]          y2_next;
    logic signed [XY_W-1:0]   xy_next;
    logic [Z_W-1:0]           mag_x;
    logic [Z_W-1:0]           mag_y;
    logic signed [MAG_W:0]    xs;
    logic signed [MAG_W:0]    ys;
    logic [SQ_W:0]            sum_sq;
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] diff_sh;
    logic signed [XY_W:0]     xy2;
    logic signed [XY_W:0]     xy2_sh;
    logic                     is_big;
    logic                     is_escape;

    // Magnitudes and the large-component test, done ahead of the multipliers.
    always_comb
    begin
        mag_x   = zx_reg[Z_W-1] ? Z_W'(-zx_reg) : Z_W'(zx_reg);
        mag_y   = zy_reg[Z_W-1] ? Z_W'(-zy_reg) : Z_W'(zy_reg);
        is_big  = (|mag_x[Z_W-1:MAG_W]) | (|mag_y[Z_W-1:MAG_W]);
        xs      = zx_reg[MAG_W:0];
        ys      = zy_reg[MAG_W:0];
        x2_next = SQ_W'(mag_x[MAG_W-1:0]) * SQ_W'(mag_x[MAG_W-1:0]);
        y2_next = SQ_W'(mag_y[MAG_W-1:0]) * SQ_W'(mag_y[MAG_W-1:0]);
        xy_next = XY_W'(xs) * XY_W'(ys);
    end

    // Escape test and next z from the registered products.
    always_comb
    begin
        sum_sq    = {1'b0, x2_reg} + {1'b0, y2_reg};
        is_escape = sum_sq[SQ_W];
        diff      = signed'({1'b0, x2_reg}) - signed'({1'b0, y2_reg});
        diff_sh   = diff >>> FRAC_BITS;
        xy2       = {xy_reg, 1'b0};
        xy2_sh    = xy2 >>> FRAC_BITS;
        zx_next   = Z_W'(diff_sh) + Z_W'(c_real_reg);
        zy_next   = Z_W'(xy2_sh) + Z_W'(c_imag_reg);
    end

    assign status = '{big: is_big, escape: is_escape};

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            c_real_reg <= c_real;
            c_imag_reg <= c_imag;
            zx_reg     <= Z_W'(c_real);
            zy_reg     <= Z_W'(c_imag);
        end
        else if (ctrl.update)
        begin
            zx_reg <= zx_next;
            zy_reg <= zy_next;
        end
        if (ctrl.mul_en)
        begin
            x2_reg <= x2_next;
            y2_reg <= y2_next;
            xy_reg <= xy_next;
        end
    end

endmodule

>>> sv/met_seq.sv
// Sequencer: iteration counter, limit test, state machine and result register.
module met_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [met_pkg::CNT_W-1:0]   iteration_count,
    input  logic [met_pkg::CNT_W-1:0]   max_iterations,
    input  met_pkg::status_t            status,
    output met_pkg::ctrl_t              ctrl
);
    import met_pkg::*;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [CNT_W-1:0]   out_count_reg;
    logic [CNT_W-1:0]   out_count_next;
    logic               limit_hit;
    logic               out_free;

    assign limit_hit = count_reg >= max_iterations;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (limit_hit || status.big)
                    state_next = ST_FINISH;
                else
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (status.escape)
                    state_next = ST_FINISH;
                else
                    state_next = ST_MUL;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl           = '0;
        in_stall       = 1'b1;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_count_next = out_count_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                ctrl.load  = in_valid;
                count_next = '0;
            end
            ST_MUL:
            begin
                ctrl.mul_en = 1'b1;
            end
            ST_ADD:
            begin
                if (!status.escape)
                begin
                    ctrl.update = 1'b1;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = count_reg;
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_count_reg <= out_count_next;
    end

    assign out_valid       = out_valid_reg;
    assign iteration_count = out_count_reg;

endmodule

>>> sv/mandelbrot_escape_time_top.sv
// Top level of the Mandelbrot escape-time counter with its limit register.
//
//   Channel  Handshake            Payload
//   -------  -------------------  -------------------------------------------
//   input    in_valid / in_stall   c_real, c_imag (signed Q4.28)
//   output   out_valid / out_stall iteration_count (12 bits)
//   config   cfg_wr_en            cfg_wr_data -> max_iterations (reset 511)
//
// A point stops at the limit or on a component of magnitude 2 or more in the
// multiply state, and on the sum of squares in the add state. Each iteration
// passes through the three multipliers of the shared iteration unit, whose
// products are registered, and then through its escape test and update adders.
// After a result is written the sequencer returns to idle before the next word
// is taken. The input stalls while a point is in flight. A finished result
// waits in the output register under out_stall while the next point is already
// accepted and iterated. Reset is asynchronous and active low; it clears the
// control state and sets the limit to 511.
module mandelbrot_escape_time_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [met_pkg::C_W-1:0] c_real,
    input  logic signed [met_pkg::C_W-1:0] c_imag,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [met_pkg::CNT_W-1:0]      iteration_count,
    input  logic                           cfg_wr_en,
    input  logic [met_pkg::CNT_W-1:0]      cfg_wr_data
);
    import met_pkg::*;

    logic [CNT_W-1:0] max_iterations_reg;
    logic [CNT_W-1:0] max_iterations_next;
    ctrl_t            ctrl;
    status_t          status;

    // The user writes the limit register only while no point is in flight; the block does not enforce it.
    assign max_iterations_next = cfg_wr_en ? cfg_wr_data : max_iterations_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_iterations_reg <= MAX_ITER_RESET;
        else
            max_iterations_reg <= max_iterations_next;
    end

    // The sequencer decides when to square, when to test and when to stop.
    met_seq u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .iteration_count (iteration_count),
        .max_iterations  (max_iterations_reg),
        .status          (status),
        .ctrl            (ctrl)
    );

    // The iteration unit holds z and c and does all of the arithmetic on them.
    met_iter_unit u_iter (
        .clk    (clk),
        .c_real (c_real),
        .c_imag (c_imag),
        .ctrl   (ctrl),
        .status (status)
    );

    // After a word is accepted the block stalls its input in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted twice in a row");

    // A count never runs past the configured limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (iteration_count <= max_iterations_reg))
        else $error("iteration count exceeds limit");

    // A new result only appears after a point was being worked on.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a point in flight");

endmodule

>>> test/mandelbrot_escape_time_top_tb.sv
// Self-checking testbench for the Mandelbrot escape-time counter.
module mandelbrot_escape_time_top_tb;

    import met_pkg::*;

    // One in Q4.28 and a few landmarks of the plane in that format.
    localparam int ONE         = 1 << FRAC_BITS;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam logic [CNT_W-1:0] LIMIT_ZERO = '0;
    localparam logic [CNT_W-1:0] LIMIT_MAX  = '1;
    localparam int NEAR_RE [4] = '{-201326592, 67108864, -27138932, -469762048};
    localparam int NEAR_IM [4] = '{26843546, 0, 256704726, 0};

    // Keeps the limit register as the block should hold it, predicts the count of
    // every accepted point and compares the result words against those counts.
    class escape_scoreboard;
        logic [CNT_W-1:0] limit;
        logic [CNT_W-1:0] expected_counts [$];
        int               errors;

        function new();
            limit  = MAX_ITER_RESET;
            errors = 0;
        endfunction

        function void set_limit(input logic [CNT_W-1:0] value);
            limit = value;
        endfunction

        // Escape-time iteration at full precision; shifts of signed values floor.
        function logic [CNT_W-1:0] escape_count(input logic signed [C_W-1:0] cr,
                                                input logic signed [C_W-1:0] ci);
            longint      cx;
            longint      cy;
            longint      x;
            longint      y;
            longint      x2;
            longint      y2;
            longint      xy;
            longint      big;
            longint      four;
            int unsigned n;
            cx   = cr;
            cy   = ci;
            x    = cx;
            y    = cy;
            big  = longint'(1) <<< (FRAC_BITS + 1);
            four = longint'(1) <<< (2 * FRAC_BITS + 2);
            n    = 0;
            while (n < limit)
            begin
                if (x >= big || x <= -big || y >= big || y <= -big)
                    break;
                x2 = x * x;
                y2 = y * y;
                if (x2 + y2 >= four)
                    break;
                xy = x * y;
                x  = ((x2 - y2) >>> FRAC_BITS) + cx;
                y  = ((2 * xy) >>> FRAC_BITS) + cy;
                n++;
            end
            return n[CNT_W-1:0];
        endfunction

        function void note_point(input logic signed [C_W-1:0] cr,
                                 input logic signed [C_W-1:0] ci);
            expected_counts.push_back(escape_count(cr, ci));
        endfunction

        function void check_count(input logic [CNT_W-1:0] got);
            logic [CNT_W-1:0] want;
            if (expected_counts.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("result word %0d arrived with no point outstanding", got);
                return;
            end
            want = expected_counts.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("iteration_count mismatch: expected %0d, got %0d", want, got);
            end
        endfunction

        function int pending();
            return expected_counts.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic signed [C_W-1:0]  c_real;
    logic signed [C_W-1:0]  c_imag;
    logic                   out_valid;
    logic                   out_stall;
    logic [CNT_W-1:0]       iteration_count;
    logic                   cfg_wr_en;
    logic [CNT_W-1:0]       cfg_wr_data;

    escape_scoreboard sb = new();

    // Set by the sender when it wants the receiver to hold off for a long stretch;
    // the receiver clears it once the stretch is over.
    bit hold_request = 1'b0;
    // Remaining words of a burst without idling, per side: 0 is the sender, 1 the
    // receiver.
    int calm_left [2] = '{0, 0};
    int cycles = 0;

    mandelbrot_escape_time_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .c_real          (c_real),
        .c_imag          (c_imag),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .iteration_count (iteration_count),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gap length in cycles: mostly none or short, now and then long, and from
    // time to time a burst of words with no gap at all.
    function automatic int pick_gap(input int side);
        int r;
        if (calm_left[side] > 0)
        begin
            calm_left[side]--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            calm_left[side] = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Both handshakes are sampled at the rising edge, before the block's own
    // registers update, so the values seen are the ones the block acts on.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_point(c_real, c_imag);
        if (rst_n && out_valid && !out_stall)
            sb.check_count(iteration_count);
    end

    // Receiver: random stalls of random length, plus one long hold-off on request.
    // While it holds off, the result register stays full, the next point finishes
    // behind it and the block has to stall its input.
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            n = pick_gap(1);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    end

    // Offers one word, after a random gap, and returns at the falling edge after it
    // was taken. Valid stays high on return so that back-to-back words need no
    // drop in between; whoever pauses next lowers it.
    task automatic send_point(input logic signed [C_W-1:0] cr,
                              input logic signed [C_W-1:0] ci);
        int gap;
        gap = pick_gap(0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        c_real   <= cr;
        c_imag   <= ci;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Steps to the next falling edge, then waits until every predicted count has come back.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (sb.pending() != 0);
    endtask

    // The limit only changes while the block is idle: every point yields a result,
    // so once all results are back the block is done, and the task waits on after that
    // to cover the return of its state machine to idle.
    task automatic write_limit(input logic [CNT_W-1:0] value);
        wait_drained();
        repeat (4) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_limit(value);
    endtask

    // Random points: most inside the interesting part of the plane, where counts spread
    // over the whole range, some around slow boundary regions, some uniform in the square
    // from -2 to 2, and some full-width noise that mostly escapes at once but toggles every bit.
    task automatic random_point(output logic signed [C_W-1:0] cr,
                                output logic signed [C_W-1:0] ci);
        int r;
        int k;
        r = $urandom_range(0, 99);
        if (r < 15)
        begin
            cr = $urandom();
            ci = $urandom();
        end
        else if (r < 75)
        begin
            cr = -2 * ONE + int'($urandom_range(0, 5 * ONE / 2));
            ci = int'($urandom_range(0, 5 * ONE / 2)) - 5 * ONE / 4;
        end
        else if (r < 90)
        begin
            k  = $urandom_range(0, 3);
            cr = NEAR_RE[k] + int'($urandom_range(0, 1 << 21)) - (1 << 20);
            ci = NEAR_IM[k] + int'($urandom_range(0, 1 << 21)) - (1 << 20);
        end
        else
        begin
            cr = int'($urandom_range(0, 4 * ONE - 1)) - 2 * ONE;
            ci = int'($urandom_range(0, 4 * ONE - 1)) - 2 * ONE;
        end
    endtask

    // Directed points at the reset limit: the origin, the extremes of both fields,
    // components exactly at and just under 2, small components whose squares sum
    // past 4, a point right at the escape circle, and slow boundary points.
    task automatic run_directed();
        send_point(0, 0);
        send_point(-2 * ONE, 0);
        send_point(32'sh7FFFFFFF, 32'sh7FFFFFFF);
        send_point(32'sh80000000, 32'sh80000000);
        send_point(32'sh7FFFFFFF, 32'sh80000000);
        send_point(ONE / 4, 0);
        send_point(-ONE, 0);
        send_point(0, ONE);
        send_point(0, -ONE);
        send_point(0, 2 * ONE);
        send_point(2 * ONE - 1, 0);
        send_point(-2 * ONE + 1, 0);
        send_point(3 * ONE / 2, 3 * ONE / 2);
        send_point(32'sh16A09E66, 32'sh16A09E66);
        send_point(-1, -1);
        send_point(1, 1);
        send_point(32'sh55555555, 32'shAAAAAAAA);
        send_point(32'shAAAAAAAA, 32'sh55555555);
        send_point(-3 * ONE / 4, ONE / 10);
        send_point(ONE / 4 + 1, 0);
        send_point(-3 * ONE / 4, 0);
        in_valid <= 1'b0;
    endtask

    // One setting of the limit and a run of random points under it. A long
    // receiver hold-off can be asked for at the start, and the sender can pause
    // halfway until every outstanding result is back.
    task automatic run_phase(input logic [CNT_W-1:0] limit, input int n_items,
                             input bit hold, input bit pause_midway);
        logic signed [C_W-1:0] cr;
        logic signed [C_W-1:0] ci;
        write_limit(limit);
        if (hold)
            hold_request = 1'b1;
        for (int i = 0; i < n_items; i++)
        begin
            if (pause_midway && i == n_items / 2)
            begin
                in_valid <= 1'b0;
                wait_drained();
            end
            random_point(cr, ci);
            send_point(cr, ci);
        end
        in_valid <= 1'b0;
    endtask

    // Main sequence: reset, directed points, then phases over several limits
    // including zero, one, the reset value and the largest value. Phases with
    // large limits are kept short since a point inside the set is iterated
    // until its count reaches the limit.
    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        c_real      = '0;
        c_imag      = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        run_phase(LIMIT_ZERO, 60, 1'b0, 1'b0);
        run_phase(12'd1, 60, 1'b0, 1'b0);
        run_phase(LIMIT_MAX, 6, 1'b0, 1'b0);
        for (int k = 0; k < 3; k++)
            run_phase(CNT_W'($urandom_range(2, 40)), 100, 1'b0, 1'b0);
        run_phase(12'd20, 100, 1'b1, 1'b1);
        run_phase(MAX_ITER_RESET, 200, 1'b0, 1'b0);
        for (int k = 0; k < 3; k++)
            run_phase(CNT_W'($urandom_range(41, 255)), 100, 1'b0, 1'b0);
        run_phase(12'd2048, 10, 1'b0, 1'b0);
        run_phase(CNT_W'($urandom_range(2, 100)), 113, 1'b0, 1'b1);

        // Let any stray result word show up before the verdict.
        wait_drained();
        repeat (20) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("mandelbrot_escape_time_top_tb: done, clean");
        else
            $display("mandelbrot_escape_time_top_tb: done, errors");
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("mandelbrot_escape_time_top_tb: done, errors");
        $finish;
    end

endmodule
